[src/outward_face_normals_assert.svh]
// Assertion macros for the outward face normal block.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef OUTWARD_FACE_NORMALS_ASSERT_SVH
`define OUTWARD_FACE_NORMALS_ASSERT_SVH

// same-cycle implication
`define OFN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OFN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ofn_pkg.sv]
// Package for the outward face normal block: widths, types, sequencer states.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package ofn_pkg;

  // store and field widths
  localparam int unsigned MaxVertices  = 1024;
  localparam int unsigned AddrW        = $clog2(MaxVertices);
  localparam int unsigned CntW         = AddrW + 1;
  localparam int unsigned CoordW       = 24;
  localparam int unsigned SumW         = CoordW + CntW - 1;
  localparam int unsigned NormW        = 16;
  localparam int unsigned NormFracBits = 14;

  // datapath widths
  localparam int unsigned EdgeW   = CoordW + 1;
  localparam int unsigned DevW    = CoordW + 3;
  localparam int unsigned CrossW  = 2 * EdgeW + 1;
  localparam int unsigned MagW    = CrossW - 1;
  localparam int unsigned ScaleW  = 30;
  localparam int unsigned RootW   = ScaleW + 1;
  localparam int unsigned SqW     = 2 * RootW;
  localparam int unsigned DivNumW = ScaleW + NormFracBits + 1;
  localparam int unsigned MulW    = 32;
  localparam int unsigned ProdW   = 2 * MulW;

  // sequence lengths
  localparam int unsigned CrossLast = 6;
  localparam int unsigned MacLast   = 3;
  localparam int unsigned SqLast    = RootW - 1;
  localparam int unsigned DivLast   = DivNumW - 1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [NormW-1:0]  norm_t;
  typedef logic [AddrW-1:0]         vidx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CDIV,
    ST_READ,
    ST_CROSS,
    ST_CHECK,
    ST_NORM,
    ST_LEN,
    ST_SQRT,
    ST_DOT,
    ST_NDIV,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

[src/ofn_in_if.sv]
// Input channel: one vertex load or one emit tick per word.
// Depends on ofn_pkg.
`default_nettype none

interface ofn_in_if;
  import ofn_pkg::*;

  logic   valid;
  logic   ready;
  logic   action;
  coord_t coord_x;
  coord_t coord_y;
  coord_t coord_z;

  modport source (output valid, action, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, action, coord_x, coord_y, coord_z, output ready);
endinterface

`default_nettype wire

[src/ofn_out_if.sv]
// Output channel: one per-vertex normal word.
// Depends on ofn_pkg.
`default_nettype none

interface ofn_out_if;
  import ofn_pkg::*;

  logic  valid;
  logic  ready;
  norm_t normal_x;
  norm_t normal_y;
  norm_t normal_z;
  vidx_t vertex_index;
  logic  degenerate;
  logic  overflowed;
  logic  last_of_triangle;
  logic  last_of_mesh;

  modport source (output valid, normal_x, normal_y, normal_z, vertex_index, degenerate,
                  overflowed, last_of_triangle, last_of_mesh, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, vertex_index, degenerate,
                  overflowed, last_of_triangle, last_of_mesh, output ready);
endinterface

`default_nettype wire

[src/ofn_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module ofn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write, read-first
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/outward_face_normals.sv]
// Outward face normals: vertex store, centroid, per-triangle unit normal.
// Depends on ofn_pkg, ofn_in_if, ofn_out_if, ofn_ram, outward_face_normals_assert.svh.
//
//   channel | dir | words
//   in_i    | in  | load vertex (action 0) or emit tick (action 1)
//   out_o   | out | three normal words per triangle
//
// A load is accepted in the idle state. The first emit tick runs three
// 45-step divisions for the centroid. Each later emit tick runs
// 4 store reads, the multiplies for the cross product, up to 29
// normalize shifts, 31 square root steps and three 45-step divisions on
// the bit-serial root and divider; then 3 output words. A degenerate
// triangle skips from the check straight to its output words.
// Reset clears control state only; the vertex store is not cleared.
// The input is stalled while the centroid or a triangle is worked on or its words wait.
`default_nettype none

`include "outward_face_normals_assert.svh"

module outward_face_normals (
  input  logic     clk_i,
  input  logic     rst_ni,
  ofn_in_if.sink   in_i,
  ofn_out_if.source out_o
);
  import ofn_pkg::*;

  state_e state_q, state_d;

  logic in_fire, out_fire, clear_blk, last_mesh, tri_fits;

  // block state
  logic [CntW-1:0]        total_q, ptr_q;
  logic                   emitting_q, ovf_q;
  logic signed [SumW-1:0] sum_q [3];
  coord_t                 cent_q [3];

  // sequencing counters
  logic [1:0] rd_cnt_q, out_k_q, dv_idx_q;
  logic [2:0] mac_cnt_q, mac_j;
  logic [4:0] sq_cnt_q;
  logic [5:0] dv_cnt_q;

  // store
  logic              ram_we;
  logic [AddrW-1:0]  ram_addr;
  logic [CoordW-1:0] rd_x, rd_y, rd_z;

  // triangle datapath
  coord_t                   vx_q [3], vy_q [3], vz_q [3];
  logic signed [EdgeW-1:0]  e1 [3], e2 [3];
  logic signed [DevW-1:0]   dev [3];
  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [ProdW-1:0]  mul_p, prod_q, tmp_q, acc_q, acc_sum;
  logic signed [CrossW-1:0] cr_q [3];
  logic [MagW-1:0]          m_q [3];
  logic [MagW-1:0]          m_or;
  logic signed [ScaleW:0]   sc [3];
  logic [2:0]               neg_q;
  logic                     degen_q, dotneg_q, norm_ok, cr_zero;
  norm_t                    nrm_q [3];

  // square root
  logic [SqW-1:0]    sq_src_q;
  logic [RootW+1:0]  sq_rem_q, sq_rem_n;
  logic [RootW-1:0]  sq_root_q;
  logic [RootW+3:0]  sq_part, sq_trial;
  logic              sq_ge;

  // divider
  logic [DivNumW-1:0] dv_num_q, dv_num_n, ld_num;
  logic [RootW-1:0]   dv_den_q, dv_rem_q, dv_rem_n, ld_den;
  logic [RootW:0]     dv_trial;
  logic               dv_ge, dv_load;
  logic [1:0]         ld_idx;
  logic [SumW-1:0]    sum_mag [3];
  logic [NormFracBits:0] q_cl;
  norm_t              nrm_val;
  coord_t             cent_val;

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_fire = out_o.valid & out_o.ready;

  assign last_mesh = ({1'b0, ptr_q} + (CntW + 1)'(6)) > {1'b0, total_q};
  assign tri_fits  = ({1'b0, ptr_q} + (CntW + 1)'(3)) <= {1'b0, total_q};

  assign clear_blk = (in_fire && in_i.action &&
                      ((!emitting_q && total_q < CntW'(3)) || (emitting_q && !tri_fits)))
                   || (out_fire && out_k_q == 2'd2 && last_mesh);

  // vertex store, one RAM per coordinate
  assign ram_we   = in_fire && !in_i.action && !emitting_q && total_q != CntW'(MaxVertices);
  assign ram_addr = (state_q == ST_READ) ? AddrW'(ptr_q + CntW'(rd_cnt_q))
                                         : total_q[AddrW-1:0];

  ofn_ram #(.Width(CoordW), .Depth(MaxVertices)) u_ram_x (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(in_i.coord_x), .rdata_o(rd_x));
  ofn_ram #(.Width(CoordW), .Depth(MaxVertices)) u_ram_y (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(in_i.coord_y), .rdata_o(rd_y));
  ofn_ram #(.Width(CoordW), .Depth(MaxVertices)) u_ram_z (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(in_i.coord_z), .rdata_o(rd_z));

  // edges, offset from centroid, scaled signed vector
  always_comb begin
    e1[0] = EdgeW'(vx_q[1]) - EdgeW'(vx_q[0]);
    e1[1] = EdgeW'(vy_q[1]) - EdgeW'(vy_q[0]);
    e1[2] = EdgeW'(vz_q[1]) - EdgeW'(vz_q[0]);
    e2[0] = EdgeW'(vx_q[2]) - EdgeW'(vx_q[0]);
    e2[1] = EdgeW'(vy_q[2]) - EdgeW'(vy_q[0]);
    e2[2] = EdgeW'(vz_q[2]) - EdgeW'(vz_q[0]);
    dev[0] = DevW'(vx_q[0]) + DevW'(vx_q[1]) + DevW'(vx_q[2])
           - (DevW'(cent_q[0]) + (DevW'(cent_q[0]) <<< 1));
    dev[1] = DevW'(vy_q[0]) + DevW'(vy_q[1]) + DevW'(vy_q[2])
           - (DevW'(cent_q[1]) + (DevW'(cent_q[1]) <<< 1));
    dev[2] = DevW'(vz_q[0]) + DevW'(vz_q[1]) + DevW'(vz_q[2])
           - (DevW'(cent_q[2]) + (DevW'(cent_q[2]) <<< 1));
    for (int i = 0; i < 3; i++) begin
      sc[i]      = neg_q[i] ? -(ScaleW + 1)'(m_q[i][ScaleW-1:0])
                            : (ScaleW + 1)'(m_q[i][ScaleW-1:0]);
      sum_mag[i] = sum_q[i][SumW-1] ? SumW'(-sum_q[i]) : SumW'(sum_q[i]);
    end
    m_or    = m_q[0] | m_q[1] | m_q[2];
    norm_ok = (m_or[MagW-1:ScaleW] == '0) && m_or[ScaleW-1];
    cr_zero = (cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_CROSS: begin
        case (mac_cnt_q)
          3'd0: begin mul_a = MulW'(e1[1]); mul_b = MulW'(e2[2]); end
          3'd1: begin mul_a = MulW'(e1[2]); mul_b = MulW'(e2[1]); end
          3'd2: begin mul_a = MulW'(e1[2]); mul_b = MulW'(e2[0]); end
          3'd3: begin mul_a = MulW'(e1[0]); mul_b = MulW'(e2[2]); end
          3'd4: begin mul_a = MulW'(e1[0]); mul_b = MulW'(e2[1]); end
          3'd5: begin mul_a = MulW'(e1[1]); mul_b = MulW'(e2[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_LEN: begin
        if (mac_cnt_q < 3'(MacLast)) begin
          mul_a = MulW'(m_q[mac_cnt_q[1:0]][ScaleW-1:0]);
          mul_b = mul_a;
        end
      end
      ST_DOT: begin
        if (mac_cnt_q < 3'(MacLast)) begin
          mul_a = MulW'(sc[mac_cnt_q[1:0]]);
          mul_b = MulW'(dev[mac_cnt_q[1:0]]);
        end
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign mac_j   = mac_cnt_q - 3'd1;
  assign acc_sum = (mac_cnt_q == 3'd1) ? prod_q : acc_q + prod_q;

  // square root step, two radicand bits per cycle
  assign sq_part  = {sq_rem_q, sq_src_q[SqW-1:SqW-2]};
  assign sq_trial = {2'b00, sq_root_q, 2'b01};
  assign sq_ge    = sq_part >= sq_trial;
  assign sq_rem_n = sq_ge ? (RootW + 2)'(sq_part - sq_trial) : sq_part[RootW+1:0];

  // restoring divider step, one quotient bit per cycle
  assign dv_trial = {dv_rem_q, dv_num_q[DivNumW-1]};
  assign dv_ge    = dv_trial >= {1'b0, dv_den_q};
  assign dv_rem_n = dv_ge ? RootW'(dv_trial - {1'b0, dv_den_q}) : dv_trial[RootW-1:0];
  assign dv_num_n = {dv_num_q[DivNumW-2:0], dv_ge};

  // quotient to normal component or centroid
  always_comb begin
    q_cl = (dv_num_n > DivNumW'(1 << NormFracBits)) ? (NormFracBits + 1)'(1 << NormFracBits)
                                                    : dv_num_n[NormFracBits:0];
    nrm_val  = (neg_q[dv_idx_q] ^ dotneg_q) ? -NormW'(q_cl) : NormW'(q_cl);
    cent_val = sum_q[dv_idx_q][SumW-1] ? -dv_num_n[CoordW-1:0] : dv_num_n[CoordW-1:0];
  end

  // divider operand load
  always_comb begin
    ld_idx  = (state_q == state_d) ? dv_idx_q + 2'd1 : 2'd0;
    dv_load = (state_d == ST_CDIV || state_d == ST_NDIV) &&
              (state_q != state_d || dv_cnt_q == 6'(DivLast));
    ld_num  = '0;
    if (state_d == ST_CDIV) begin
      ld_den = RootW'(total_q);
      case (ld_idx)
        2'd0:    ld_num = DivNumW'(sum_mag[0]);
        2'd1:    ld_num = DivNumW'(sum_mag[1]);
        default: ld_num = DivNumW'(sum_mag[2]);
      endcase
    end else begin
      ld_den = sq_root_q;
      case (ld_idx)
        2'd0:    ld_num = {1'b0, m_q[0][ScaleW-1:0], NormFracBits'(0)};
        2'd1:    ld_num = {1'b0, m_q[1][ScaleW-1:0], NormFracBits'(0)};
        default: ld_num = {1'b0, m_q[2][ScaleW-1:0], NormFracBits'(0)};
      endcase
      ld_num = ld_num + DivNumW'(sq_root_q[RootW-1:1]);
    end
  end

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and handshake
  always_comb begin
    state_d     = state_q;
    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_fire && in_i.action) begin
          if (!emitting_q) begin
            if (total_q >= CntW'(3)) state_d = ST_CDIV;
          end else if (tri_fits) begin
            state_d = ST_READ;
          end
        end
      end
      ST_CDIV: begin
        if (dv_cnt_q == 6'(DivLast) && dv_idx_q == 2'd2) state_d = ST_IDLE;
      end
      ST_READ: begin
        if (rd_cnt_q == 2'd3) state_d = ST_CROSS;
      end
      ST_CROSS: begin
        if (mac_cnt_q == 3'(CrossLast)) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = cr_zero ? ST_OUT : ST_NORM;
      end
      ST_NORM: begin
        if (norm_ok) state_d = ST_LEN;
      end
      ST_LEN: begin
        if (mac_cnt_q == 3'(MacLast)) state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (sq_cnt_q == 5'(SqLast)) state_d = ST_DOT;
      end
      ST_DOT: begin
        if (mac_cnt_q == 3'(MacLast)) state_d = ST_NDIV;
      end
      ST_NDIV: begin
        if (dv_cnt_q == 6'(DivLast) && dv_idx_q == 2'd2) state_d = ST_OUT;
      end
      ST_OUT: begin
        out_o.valid = 1'b1;
        if (out_fire && out_k_q == 2'd2) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // block state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      ptr_q      <= '0;
      emitting_q <= 1'b0;
      ovf_q      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i]  <= '0;
        cent_q[i] <= '0;
      end
      rd_cnt_q  <= '0;
      mac_cnt_q <= '0;
      sq_cnt_q  <= '0;
      dv_cnt_q  <= '0;
      dv_idx_q  <= '0;
      out_k_q   <= '0;
    end else begin
      if (clear_blk) begin
        total_q    <= '0;
        ptr_q      <= '0;
        emitting_q <= 1'b0;
        ovf_q      <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          sum_q[i]  <= '0;
          cent_q[i] <= '0;
        end
      end else begin
        // vertex load or drop when full
        if (in_fire && !in_i.action && !emitting_q) begin
          if (total_q == CntW'(MaxVertices)) begin
            ovf_q <= 1'b1;
          end else begin
            sum_q[0] <= sum_q[0] + SumW'(in_i.coord_x);
            sum_q[1] <= sum_q[1] + SumW'(in_i.coord_y);
            sum_q[2] <= sum_q[2] + SumW'(in_i.coord_z);
            total_q  <= total_q + CntW'(1);
          end
        end
        // first emit tick freezes the count
        if (in_fire && in_i.action && !emitting_q) begin
          emitting_q <= 1'b1;
          ptr_q      <= '0;
        end
        if (state_q == ST_CDIV && dv_cnt_q == 6'(DivLast)) begin
          cent_q[dv_idx_q] <= cent_val;
        end
        if (out_fire && out_k_q == 2'd2) begin
          ptr_q <= ptr_q + CntW'(3);
        end
      end

      // step counters restart on every state change
      if (state_d != state_q) begin
        rd_cnt_q  <= '0;
        mac_cnt_q <= '0;
        sq_cnt_q  <= '0;
        dv_cnt_q  <= '0;
        dv_idx_q  <= '0;
        out_k_q   <= '0;
      end else begin
        case (state_q)
          ST_READ:                   rd_cnt_q  <= rd_cnt_q + 2'd1;
          ST_CROSS, ST_LEN, ST_DOT:  mac_cnt_q <= mac_cnt_q + 3'd1;
          ST_SQRT:                   sq_cnt_q  <= sq_cnt_q + 5'd1;
          ST_CDIV, ST_NDIV: begin
            if (dv_cnt_q == 6'(DivLast)) begin
              dv_cnt_q <= '0;
              dv_idx_q <= dv_idx_q + 2'd1;
            end else begin
              dv_cnt_q <= dv_cnt_q + 6'd1;
            end
          end
          ST_OUT: begin
            if (out_fire) out_k_q <= out_k_q + 2'd1;
          end
          default: rd_cnt_q <= rd_cnt_q;
        endcase
      end
    end
  end

  // triangle datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;

    // capture a, b, c from the registered read data in the cycle after each read
    if (state_q == ST_READ && rd_cnt_q != 2'd0) begin
      vx_q[2'(rd_cnt_q - 2'd1)] <= coord_t'(rd_x);
      vy_q[2'(rd_cnt_q - 2'd1)] <= coord_t'(rd_y);
      vz_q[2'(rd_cnt_q - 2'd1)] <= coord_t'(rd_z);
    end

    // cross product: pairs of products
    if (state_q == ST_CROSS && mac_cnt_q != 3'd0) begin
      if (!mac_j[0]) begin
        tmp_q <= prod_q;
      end else begin
        cr_q[mac_j[2:1]] <= CrossW'(tmp_q - prod_q);
      end
    end

    // sums of products for length and orientation
    if ((state_q == ST_LEN || state_q == ST_DOT) && mac_cnt_q != 3'd0) begin
      acc_q <= acc_sum;
    end

    // magnitudes and signs
    if (state_q == ST_CHECK) begin
      degen_q <= cr_zero;
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= cr_q[i][CrossW-1];
        m_q[i]   <= cr_q[i][CrossW-1] ? MagW'(-cr_q[i]) : MagW'(cr_q[i]);
        if (cr_zero) nrm_q[i] <= '0;
      end
    end

    // bring the largest magnitude into [2^29, 2^30)
    if (state_q == ST_NORM && !norm_ok) begin
      for (int i = 0; i < 3; i++) begin
        if (m_or[MagW-1:ScaleW] != '0) begin
          m_q[i] <= m_q[i] >> 1;
        end else begin
          m_q[i] <= m_q[i] << 1;
        end
      end
    end

    // square root
    if (state_q == ST_LEN && mac_cnt_q == 3'(MacLast)) begin
      sq_src_q  <= acc_sum[SqW-1:0];
      sq_rem_q  <= '0;
      sq_root_q <= '0;
    end else if (state_q == ST_SQRT) begin
      sq_src_q  <= sq_src_q << 2;
      sq_rem_q  <= sq_rem_n;
      sq_root_q <= {sq_root_q[RootW-2:0], sq_ge};
    end

    if (state_q == ST_DOT && mac_cnt_q == 3'(MacLast)) begin
      dotneg_q <= acc_sum[ProdW-1];
    end

    // divider
    if (dv_load) begin
      dv_num_q <= ld_num;
      dv_den_q <= ld_den;
      dv_rem_q <= '0;
    end else if (state_q == ST_CDIV || state_q == ST_NDIV) begin
      dv_num_q <= dv_num_n;
      dv_rem_q <= dv_rem_n;
    end

    if (state_q == ST_NDIV && dv_cnt_q == 6'(DivLast)) begin
      nrm_q[dv_idx_q] <= nrm_val;
    end
  end

  // output word
  assign out_o.normal_x         = nrm_q[0];
  assign out_o.normal_y         = nrm_q[1];
  assign out_o.normal_z         = nrm_q[2];
  assign out_o.vertex_index     = AddrW'(ptr_q + CntW'(out_k_q));
  assign out_o.degenerate       = degen_q;
  assign out_o.overflowed       = ovf_q;
  assign out_o.last_of_triangle = (out_k_q == 2'd2);
  assign out_o.last_of_mesh     = (out_k_q == 2'd2) && last_mesh;

  // checks
  `OFN_ASSERT_IMP(a_out_blocks_in, out_o.valid, !in_i.ready, "input open while words wait")
  `OFN_ASSERT_IMP(a_norm_range, state_q == ST_LEN && mac_cnt_q == 3'd0,
                  norm_ok, "scaled magnitudes out of range")
  `OFN_ASSERT_IMP(a_tri_in_store, state_q == ST_OUT, tri_fits,
                  "triangle beyond stored vertices")
  `OFN_ASSERT_NXT(a_degen_path, state_q == ST_CHECK && cr_zero,
                  state_q == ST_OUT && degen_q && nrm_q[0] == '0, "degenerate not flagged")

endmodule

`default_nettype wire
